@@ sv/energy_vad_segmenter_macros.svh @@
// ----------------------------------------------------------------------------
// energy_vad_segmenter_macros.svh
// Assertion shorthands shared by the segmenter RTL. Every user module has
// clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VAD_SEGMENTER_MACROS_SVH
`define ENERGY_VAD_SEGMENTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define EVS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define EVS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/evs_pkg.sv @@
// ----------------------------------------------------------------------------
// evs_pkg
// Types and fixed constants of the energy VAD segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package evs_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;  // (-32768)^2 = 2^30 needs 31 bits
  localparam int ENERGY_W   = 42;
  localparam int INDEX_W    = 32;
  localparam int THR_W      = 31;
  localparam int LEN_CFG_W  = 20;
  localparam int SEG_LEN_W  = 20;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 3;

  localparam logic [ENERGY_W-1:0] ENERGY_CAP = {ENERGY_W{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_ROLL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 3'd4;

  // Register reset values
  localparam logic [THR_W-1:0]     RST_THRESHOLD = 31'd1073741;
  localparam logic [LEN_CFG_W-1:0] RST_PRE_ROLL  = 20'd4800;
  localparam logic [LEN_CFG_W-1:0] RST_SILENCE   = 20'd8000;
  localparam logic [LEN_CFG_W-1:0] RST_MIN_LEN   = 20'd4000;
  localparam logic [LEN_CFG_W-1:0] RST_MAX_LEN   = 20'd480000;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ONSET   = 2'd1,
    EV_EMIT    = 2'd2,
    EV_DISCARD = 2'd3
  } event_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           event_res;
    logic [INDEX_W-1:0]   seg_start;
    logic [SEG_LEN_W-1:0] seg_length;
    logic                 speech_active;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]     threshold;
    logic [LEN_CFG_W-1:0] pre_roll;
    logic [LEN_CFG_W-1:0] silence_needed;
    logic [LEN_CFG_W-1:0] min_len;
    logic [LEN_CFG_W-1:0] max_len;
  } cfg_t;

endpackage

`default_nettype wire

@@ sv/evs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// evs_cfg_regs
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module evs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [evs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [evs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output evs_pkg::cfg_t                       cfg_o
);
  import evs_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: cfg_d.threshold      = cfg_data_i[THR_W-1:0];
        REG_PRE_ROLL:  cfg_d.pre_roll       = cfg_data_i[LEN_CFG_W-1:0];
        REG_SILENCE:   cfg_d.silence_needed = cfg_data_i[LEN_CFG_W-1:0];
        REG_MIN_LEN:   cfg_d.min_len        = cfg_data_i[LEN_CFG_W-1:0];
        REG_MAX_LEN:   cfg_d.max_len        = cfg_data_i[LEN_CFG_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold      <= RST_THRESHOLD;
      cfg_q.pre_roll       <= RST_PRE_ROLL;
      cfg_q.silence_needed <= RST_SILENCE;
      cfg_q.min_len        <= RST_MIN_LEN;
      cfg_q.max_len        <= RST_MAX_LEN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/evs_frame_acc.sv @@
// ----------------------------------------------------------------------------
// evs_frame_acc
// Input register, square register and per-frame energy accumulator. Emits one
// frame record (energy, length, first sample index) per frame end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "energy_vad_segmenter_macros.svh"

module evs_frame_acc #(
  parameter int FRAME_MAX = 4096,
  parameter int FC_W      = 13
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // sample channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire evs_pkg::in_item_t               in_data_i,
  // frame record channel
  output logic                                 frm_valid_o,
  input  wire logic                            frm_ready_i,
  output logic [evs_pkg::ENERGY_W-1:0]         frm_energy_o,
  output logic [FC_W-1:0]                      frm_len_o,
  output logic [evs_pkg::INDEX_W-1:0]          frm_start_o
);
  import evs_pkg::*;

  // Input register
  logic                       s1_v_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic                       s1_last_q;
  // Square register
  logic                       s2_v_q;
  logic [SQ_W-1:0]            s2_sq_q;
  logic                       s2_last_q;
  // Accumulator state
  logic [ENERGY_W-1:0]        energy_q, energy_d;
  logic [FC_W-1:0]            fcount_q, fcount_d;
  logic [INDEX_W-1:0]         sidx_q;
  logic [INDEX_W-1:0]         fstart_q;
  // Frame record register
  logic                       frm_v_q;
  logic [ENERGY_W-1:0]        frm_energy_q;
  logic [FC_W-1:0]            frm_len_q;
  logic [INDEX_W-1:0]         frm_start_q;

  logic                       s1_take, s1_free, s2_take, s2_free, s3_free;
  logic                       frame_end;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [ENERGY_W:0]          energy_sum;
  logic [ENERGY_W-1:0]        energy_sat;
  logic [FC_W-1:0]            fcount_inc;

  // Stage movement; samples that do not end a frame are absorbed even while
  // a frame record waits downstream.
  assign s3_free    = !frm_v_q || frm_ready_i;
  assign s2_take    = s2_v_q && (s3_free || !frame_end);
  assign s2_free    = !s2_v_q || s2_take;
  assign s1_take    = s1_v_q && s2_free;
  assign s1_free    = !s1_v_q || s1_take;
  assign in_ready_o = s1_free;

  // Square of the registered sample
  assign sq_full = s1_sample_q * s1_sample_q;

  // Saturating accumulate and frame end detection
  assign energy_sum = {1'b0, energy_q} + (ENERGY_W+1)'(s2_sq_q);
  assign energy_sat = energy_sum[ENERGY_W] ? ENERGY_CAP : energy_sum[ENERGY_W-1:0];
  assign fcount_inc = fcount_q + FC_W'(1);
  assign frame_end  = s2_last_q || (fcount_inc == FC_W'(FRAME_MAX));

  always_comb begin
    energy_d = energy_q;
    fcount_d = fcount_q;
    if (s2_take) begin
      energy_d = frame_end ? '0 : energy_sat;
      fcount_d = frame_end ? '0 : fcount_inc;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      frm_v_q  <= 1'b0;
      energy_q <= '0;
      fcount_q <= '0;
      sidx_q   <= '0;
      fstart_q <= '0;
    end else begin
      if (s1_free) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (s2_take && frame_end) begin
        frm_v_q <= 1'b1;
      end else if (frm_ready_i) begin
        frm_v_q <= 1'b0;
      end
      energy_q <= energy_d;
      fcount_q <= fcount_d;
      if (s2_take) begin
        sidx_q <= sidx_q + INDEX_W'(1);
        if (frame_end) begin
          fstart_q <= sidx_q + INDEX_W'(1);
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_free) begin
      s1_sample_q <= in_data_i.sample;
      s1_last_q   <= in_data_i.frame_last;
    end
    if (s1_take) begin
      s2_sq_q   <= sq_full[SQ_W-1:0];
      s2_last_q <= s1_last_q;
    end
    if (s2_take && frame_end) begin
      frm_energy_q <= energy_sat;
      frm_len_q    <= fcount_inc;
      frm_start_q  <= fstart_q;
    end
  end

  assign frm_valid_o  = frm_v_q;
  assign frm_energy_o = frm_energy_q;
  assign frm_len_o    = frm_len_q;
  assign frm_start_o  = frm_start_q;

  // Checks
  `EVS_ASSERT_NOW(a_fcount_range, 1'b1, fcount_q < FC_W'(FRAME_MAX), "frame count overran")
  `EVS_ASSERT_NOW(a_empty_frame, fcount_q == '0, energy_q == '0, "energy left in empty frame")
  `EVS_ASSERT_NEXT(a_index_step, s2_take, sidx_q == $past(sidx_q) + INDEX_W'(1), "index skipped")

endmodule

`default_nettype wire

@@ sv/evs_seg_fsm.sv @@
// ----------------------------------------------------------------------------
// evs_seg_fsm
// Threshold product register, voiced decision, idle/speech segment machine
// and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "energy_vad_segmenter_macros.svh"

module evs_seg_fsm #(
  parameter int FC_W        = 13,
  parameter int LENGTH_BITS = 20
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire evs_pkg::cfg_t              cfg_i,
  // frame record channel
  input  wire logic                       frm_valid_i,
  output logic                            frm_ready_o,
  input  wire logic [evs_pkg::ENERGY_W-1:0] frm_energy_i,
  input  wire logic [FC_W-1:0]            frm_len_i,
  input  wire logic [evs_pkg::INDEX_W-1:0] frm_start_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output evs_pkg::out_item_t              out_data_o
);
  import evs_pkg::*;

  localparam int LB  = LENGTH_BITS;
  localparam int CW  = (LB > LEN_CFG_W) ? LB : LEN_CFG_W;
  localparam int PW  = THR_W + FC_W;
  localparam int PEW = (PW > ENERGY_W) ? PW : ENERGY_W;
  localparam logic [CW:0] LEN_CAP = (CW+1)'((64'd1 << LB) - 64'd1);

  // Saturating add of a frame length to a counter
  function automatic logic [LB-1:0] sat_add(input logic [CW-1:0] a, input logic [FC_W-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    return (s > LEN_CAP) ? {LB{1'b1}} : s[LB-1:0];
  endfunction

  // Product stage registers
  logic                s4_v_q;
  logic [ENERGY_W-1:0] s4_energy_q;
  logic [ENERGY_W-1:0] s4_prod_q;
  logic [FC_W-1:0]     s4_len_q;
  logic [INDEX_W-1:0]  s4_start_q;
  // Segment state
  logic                speech_q, speech_d;
  logic [LB-1:0]       idle_q, idle_d;
  logic [LB-1:0]       seglen_q, seglen_d;
  logic [LB-1:0]       silence_q, silence_d;
  logic [INDEX_W-1:0]  segbeg_q, segbeg_d;
  // Result register
  logic                out_v_q;
  out_item_t           out_q, out_d;

  logic                out_free, s4_take, s4_free;
  logic [PW-1:0]       prod_full;
  logic [PEW-1:0]      prod_ext;
  logic [ENERGY_W-1:0] prod_sat;
  logic                voiced;
  logic [CW-1:0]       pre_w;
  logic [LB-1:0]       sl_w, sr_w;
  logic [INDEX_W-1:0]  seglen_ext;
  event_e              ev;

  // Stage movement
  assign out_free    = !out_v_q || out_ready_i;
  assign s4_take     = s4_v_q && out_free;
  assign s4_free     = !s4_v_q || s4_take;
  assign frm_ready_o = s4_free;

  // Threshold times frame length, saturated
  assign prod_full = cfg_i.threshold * frm_len_i;
  assign prod_ext  = PEW'(prod_full);
  assign prod_sat  = (prod_ext > PEW'(ENERGY_CAP)) ? ENERGY_CAP : prod_ext[ENERGY_W-1:0];

  // Frame decision and candidate counter values
  assign voiced = s4_energy_q >= s4_prod_q;
  assign pre_w  = (CW'(idle_q) < CW'(cfg_i.pre_roll)) ? CW'(idle_q) : CW'(cfg_i.pre_roll);
  assign sl_w   = sat_add(CW'(seglen_q), s4_len_q);
  assign sr_w   = sat_add(CW'(silence_q), s4_len_q);

  // Segment machine
  always_comb begin
    speech_d  = speech_q;
    idle_d    = idle_q;
    seglen_d  = seglen_q;
    silence_d = silence_q;
    segbeg_d  = segbeg_q;
    ev        = EV_NONE;
    if (s4_take) begin
      if (!speech_q) begin
        if (voiced) begin
          // onset: pull in pre-roll, onset frame counted once
          segbeg_d  = s4_start_q - INDEX_W'(pre_w);
          seglen_d  = sat_add(pre_w, s4_len_q);
          silence_d = '0;
          idle_d    = '0;
          speech_d  = 1'b1;
          ev        = EV_ONSET;
        end else begin
          idle_d = sat_add(CW'(idle_q), s4_len_q);
        end
      end else begin
        seglen_d = sl_w;
        if (CW'(sl_w) >= CW'(cfg_i.max_len)) begin
          // hard cap
          speech_d = 1'b0;
          idle_d   = '0;
          ev       = EV_EMIT;
        end else if (voiced) begin
          silence_d = '0;
        end else begin
          silence_d = sr_w;
          if (CW'(sr_w) >= CW'(cfg_i.silence_needed)) begin
            speech_d = 1'b0;
            idle_d   = '0;
            ev       = (CW'(sl_w) < CW'(cfg_i.min_len)) ? EV_DISCARD : EV_EMIT;
          end
        end
      end
    end
  end

  // Result assembly
  assign seglen_ext = INDEX_W'(seglen_d);

  always_comb begin
    out_d.event_res     = ev;
    out_d.seg_start     = segbeg_d;
    out_d.seg_length    = seglen_ext[SEG_LEN_W-1:0];
    out_d.speech_active = speech_d;
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      speech_q  <= 1'b0;
      idle_q    <= '0;
      seglen_q  <= '0;
      silence_q <= '0;
      segbeg_q  <= '0;
    end else begin
      if (s4_free) begin
        s4_v_q <= frm_valid_i;
      end
      if (s4_take && (ev != EV_NONE)) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      speech_q  <= speech_d;
      idle_q    <= idle_d;
      seglen_q  <= seglen_d;
      silence_q <= silence_d;
      segbeg_q  <= segbeg_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (frm_valid_i && s4_free) begin
      s4_energy_q <= frm_energy_i;
      s4_prod_q   <= prod_sat;
      s4_len_q    <= frm_len_i;
      s4_start_q  <= frm_start_i;
    end
    if (s4_take && (ev != EV_NONE)) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Checks
  `EVS_ASSERT_NOW(a_real_event, out_v_q, out_q.event_res != EV_NONE, "empty result shown")
  `EVS_ASSERT_NOW(a_active_onset, out_v_q, out_q.speech_active == (out_q.event_res == EV_ONSET), "speech flag disagrees with event")
  `EVS_ASSERT_NOW(a_idle_clear, speech_q, idle_q == '0, "idle run kept during speech")

endmodule

`default_nettype wire

@@ sv/energy_vad_segmenter.sv @@
// ----------------------------------------------------------------------------
// energy_vad_segmenter
// Energy-threshold voice activity detector: frames the sample stream, marks
// each frame voiced or unvoiced and reports speech segments as start index
// and length.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    sample, frame_last
//   out       output     out_valid/out_ready  event_res, seg_start, ...
//   cfg       input      cfg_we               cfg_idx, cfg_data
//
// One sample is taken per cycle unless a stalled result holds a frame end; the square, the accumulate, the
// threshold product and the segment step each own one register stage.
// After the frame's last sample is taken, its result passes the square, frame record, product and result registers.
// Reset clears all control state at once and loads the register defaults; there is no start-up sweep.
// A stalled result holds the frame stage, while samples inside a frame keep
// being absorbed by the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_vad_segmenter #(
  parameter int FRAME_MAX   = 4096,
  parameter int LENGTH_BITS = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire evs_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output evs_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [evs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [evs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import evs_pkg::*;

  localparam int FC_W = $clog2(FRAME_MAX + 1);

  cfg_t                cfg;
  logic                frm_valid, frm_ready;
  logic [ENERGY_W-1:0] frm_energy;
  logic [FC_W-1:0]     frm_len;
  logic [INDEX_W-1:0]  frm_start;

  evs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  evs_frame_acc #(
    .FRAME_MAX (FRAME_MAX),
    .FC_W      (FC_W)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .frm_valid_o  (frm_valid),
    .frm_ready_i  (frm_ready),
    .frm_energy_o (frm_energy),
    .frm_len_o    (frm_len),
    .frm_start_o  (frm_start)
  );

  evs_seg_fsm #(
    .FC_W        (FC_W),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_seg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .frm_valid_i  (frm_valid),
    .frm_ready_o  (frm_ready),
    .frm_energy_i (frm_energy),
    .frm_len_i    (frm_len),
    .frm_start_i  (frm_start),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire
